// ===== rtl/bmmd_pkg.sv =====
package bmmd_pkg;

    localparam int unsigned ADDR_W   = 16;
    localparam int unsigned DATA_W   = 8;
    localparam int unsigned REGION_W = 4;
    localparam int unsigned OFFSET_W = 17;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_RAM_CONFIG   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE_CONFIG  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ZP_TARGET    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SP_TARGET    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COMPAT_MODE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COMPAT_BANK  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PORT_LINES   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_CART_PRESENT = 3'd7;

    localparam logic [REGION_W-1:0] REGION_RAM           = 4'd0;
    localparam logic [REGION_W-1:0] REGION_BASIC         = 4'd1;
    localparam logic [REGION_W-1:0] REGION_FUNCTION_ROM  = 4'd2;
    localparam logic [REGION_W-1:0] REGION_CARTRIDGE     = 4'd3;
    localparam logic [REGION_W-1:0] REGION_EDITOR        = 4'd4;
    localparam logic [REGION_W-1:0] REGION_KERNAL        = 4'd5;
    localparam logic [REGION_W-1:0] REGION_CHARSET       = 4'd6;
    localparam logic [REGION_W-1:0] REGION_COMPAT_BASIC  = 4'd7;
    localparam logic [REGION_W-1:0] REGION_COMPAT_KERNAL = 4'd8;

    localparam logic [1:0] SEL_SYSTEM_ROM   = 2'd0;
    localparam logic [1:0] SEL_FUNCTION_ROM = 2'd1;
    localparam logic [1:0] SEL_CARTRIDGE    = 2'd2;

    localparam logic [ADDR_W-1:0] SHARED_RAM_SPAN [4] =
        '{16'h0400, 16'h1000, 16'h2000, 16'h4000};

    localparam logic [ADDR_W-1:0] BASIC_BASE  = 16'h4000;
    localparam logic [ADDR_W-1:0] CHARSET_OFS = 16'h1000;

    typedef struct packed {
        logic              cmd;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] write_data;
    } req_t;

    typedef struct packed {
        logic [REGION_W-1:0] region;
        logic [OFFSET_W-1:0] offset;
        logic                store_enable;
        logic [DATA_W-1:0]   store_data;
        logic                io_visible;
    } rsp_t;

    function automatic logic in_common(input logic [3:0] ram_cfg, input logic [ADDR_W-1:0] a);
        logic [ADDR_W-1:0] size;
        begin
            size = SHARED_RAM_SPAN[ram_cfg[1:0]];
            in_common = (ram_cfg[2] && (a < size)) || (ram_cfg[3] && (a >= (16'h0 - size)));
        end
    endfunction

endpackage

// ===== rtl/banked_memory_map_decoder.sv =====
// Banked memory map decoder: turns each CPU access into a region select and
// an offset within that region, for native and compatible mappings.
// Channels:
//   req  - valid/ready, one access item (cmd, address, write_data).
//   rsp  - valid/ready, one result item per access, in order.
//   cfg  - valid/ready register write (cfg_index, cfg_data), always ready;
//          write only while no access is in flight.
// An accepted access passes through the input register and the decode logic
// into the result register, which presents its result.
// Throughput: one access per cycle while rsp_ready is high, set by the single decode stage.
// Reset: all configuration registers return to their defaults (stack page
// target 1, port lines 7, the rest 0) and both stages are emptied.
// Stall: when rsp_ready is low the result register holds; the input stage
// still takes one more access and then holds, and req_ready drops.
module banked_memory_map_decoder (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_ready,
    input  bmmd_pkg::req_t            req,
    output logic                      rsp_valid,
    input  logic                      rsp_ready,
    output bmmd_pkg::rsp_t            rsp,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [bmmd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bmmd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import bmmd_pkg::*;

    logic [3:0] ram_config_reg;
    logic [7:0] mode_config_reg;
    logic [8:0] zp_target_reg;
    logic [8:0] sp_target_reg;
    logic       compat_mode_reg;
    logic       compat_bank_reg;
    logic [2:0] port_lines_reg;
    logic       cart_present_reg;

    logic s1_valid_reg;
    req_t s1_reg;
    logic s2_valid_reg;
    rsp_t s2_reg;
    rsp_t s2_next;

    logic s2_load;
    logic s1_load;

    logic [ADDR_W-1:0]   a;
    logic                common_a;
    logic                zp_bank;
    logic                sp_bank;
    logic [OFFSET_W-1:0] ram_off;
    logic [1:0]          lsel;
    logic [1:0]          usel;
    logic                lo;
    logic                hi;
    logic                ch;
    logic [REGION_W-1:0] rd_region;
    logic [OFFSET_W-1:0] rd_off;
    logic                io;

    assign cfg_ready = 1'b1;
    assign s2_load   = s1_valid_reg && (!s2_valid_reg || rsp_ready);
    assign req_ready = !s1_valid_reg || s2_load;
    assign s1_load   = req_valid && req_ready;
    assign rsp_valid = s2_valid_reg;
    assign rsp       = s2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ram_config_reg   <= '0;
            mode_config_reg  <= '0;
            zp_target_reg    <= 9'd0;
            sp_target_reg    <= 9'd1;
            compat_mode_reg  <= 1'b0;
            compat_bank_reg  <= 1'b0;
            port_lines_reg   <= 3'd7;
            cart_present_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_RAM_CONFIG:   ram_config_reg   <= cfg_data[3:0];
                CFG_MODE_CONFIG:  mode_config_reg  <= cfg_data[7:0];
                CFG_ZP_TARGET:    zp_target_reg    <= cfg_data[8:0];
                CFG_SP_TARGET:    sp_target_reg    <= cfg_data[8:0];
                CFG_COMPAT_MODE:  compat_mode_reg  <= cfg_data[0];
                CFG_COMPAT_BANK:  compat_bank_reg  <= cfg_data[0];
                CFG_PORT_LINES:   port_lines_reg   <= cfg_data[2:0];
                CFG_CART_PRESENT: cart_present_reg <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_ready)
            begin
                s1_valid_reg <= req_valid;
            end
            if (!s2_valid_reg || rsp_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_reg <= req;
        end
        if (s2_load)
        begin
            s2_reg <= s2_next;
        end
    end

    // RAM location under the address
    always_comb
    begin
        a        = s1_reg.address;
        common_a = in_common(ram_config_reg, a);
        zp_bank  = zp_target_reg[8] && !in_common(ram_config_reg, {zp_target_reg[7:0], 8'h00});
        sp_bank  = sp_target_reg[8] && !in_common(ram_config_reg, {sp_target_reg[7:0], 8'h00});
        if (compat_mode_reg)
        begin
            ram_off = {compat_bank_reg && !common_a, a};
        end
        else if (a[15:8] == 8'h00)
        begin
            ram_off = {zp_bank, zp_target_reg[7:0], a[7:0]};
        end
        else if (a[15:8] == 8'h01)
        begin
            ram_off = {sp_bank, sp_target_reg[7:0], a[7:0]};
        end
        else
        begin
            ram_off = {mode_config_reg[6] && !common_a, a};
        end
    end

    // read decode
    always_comb
    begin
        lsel      = mode_config_reg[3:2];
        usel      = mode_config_reg[5:4];
        lo        = port_lines_reg[0];
        hi        = port_lines_reg[1];
        ch        = port_lines_reg[2];
        rd_region = REGION_RAM;
        rd_off    = ram_off;
        if (compat_mode_reg)
        begin
            if (a[15:13] == 3'b101 && lo && hi)
            begin
                rd_region = REGION_COMPAT_BASIC;
                rd_off    = {4'd0, a[12:0]};
            end
            else if (a[15:12] == 4'hD && !ch && (lo || hi))
            begin
                rd_region = REGION_CHARSET;
                rd_off    = {5'd0, a[11:0]};
            end
            else if (a[15:13] == 3'b111 && hi)
            begin
                rd_region = REGION_COMPAT_KERNAL;
                rd_off    = {4'd0, a[12:0]};
            end
        end
        else if (a[15:14] == 2'b01)
        begin
            if (!mode_config_reg[1])
            begin
                rd_region = REGION_BASIC;
                rd_off    = {1'b0, a - BASIC_BASE};
            end
        end
        else if (a[15:14] == 2'b10)
        begin
            if (lsel == SEL_SYSTEM_ROM)
            begin
                rd_region = REGION_BASIC;
                rd_off    = {1'b0, a - BASIC_BASE};
            end
            else if (lsel == SEL_FUNCTION_ROM)
            begin
                rd_region = REGION_FUNCTION_ROM;
                rd_off    = {2'd0, a[14:0]};
            end
            else if (lsel == SEL_CARTRIDGE && cart_present_reg)
            begin
                rd_region = REGION_CARTRIDGE;
                rd_off    = {2'd0, a[14:0]};
            end
        end
        else if (a[15:14] == 2'b11)
        begin
            if (usel == SEL_FUNCTION_ROM)
            begin
                rd_region = REGION_FUNCTION_ROM;
                rd_off    = {2'd0, a[14:0]};
            end
            else if (usel == SEL_CARTRIDGE && cart_present_reg)
            begin
                rd_region = REGION_CARTRIDGE;
                rd_off    = {2'd0, a[14:0]};
            end
            else if (usel == SEL_SYSTEM_ROM)
            begin
                if (a[13:12] == 2'b00)
                begin
                    rd_region = REGION_EDITOR;
                    rd_off    = {5'd0, a[11:0]};
                end
                else if (a[13:12] == 2'b01)
                begin
                    if (mode_config_reg[0] && !mode_config_reg[6])
                    begin
                        rd_region = REGION_CHARSET;
                        rd_off    = {1'b0, CHARSET_OFS | {4'd0, a[11:0]}};
                    end
                end
                else
                begin
                    rd_region = REGION_KERNAL;
                    rd_off    = {4'd0, a[12:0]};
                end
            end
        end
    end

    always_comb
    begin
        if (compat_mode_reg)
        begin
            io = ch && (lo || hi);
        end
        else
        begin
            io = !mode_config_reg[0];
        end
        s2_next.io_visible = io;
        if (s1_reg.cmd)
        begin
            s2_next.region       = REGION_RAM;
            s2_next.offset       = ram_off;
            s2_next.store_enable = 1'b1;
            s2_next.store_data   = s1_reg.write_data;
        end
        else
        begin
            s2_next.region       = rd_region;
            s2_next.offset       = rd_off;
            s2_next.store_enable = 1'b0;
            s2_next.store_data   = '0;
        end
    end

endmodule
